>>> rtl/core/assert_macros.svh
// assertion macros included by the hasher top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
`define CHK_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

>>> rtl/core/sha_pkg.sv
// types, constants and round functions for the sha-256 hasher
// no dependencies
package sha_pkg;

  localparam int QDepth = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROUND, ST_FOLD, ST_PAD, ST_EMIT
  } back_state_t;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      case (i)
        6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

>>> rtl/core/sha_queue.sv
// input queue between the item front end and the compression engine
// depends on sha_pkg
module sha_queue
  import sha_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t pop_item,
  output logic  empty
);
  localparam int AW = $clog2(QDepth);
  item_t mem [QDepth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] count;

  assign full = (count == (AW+1)'(QDepth));
  assign empty = (count == '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

>>> rtl/core/sha_front.sv
// front end: accepts items, drops empty ones, feeds the queue
// depends on sha_pkg, sha_queue
module sha_front
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       valid_in,
  output logic       ready_in,
  input  logic [7:0] data_byte,
  input  logic       has_byte,
  input  logic       last,
  input  logic       pop,
  output item_t      pop_item,
  output logic       empty
);
  logic full, push;
  item_t it;
  assign it = '{data_byte: data_byte, has_byte: has_byte, last: last};
  assign ready_in = !full;
  assign push = valid_in && !full && (has_byte || last);

  sha_queue u_queue (
    .clk, .rst, .push, .push_item(it), .full, .pop, .pop_item, .empty
  );
endmodule

>>> rtl/core/sha_back.sv
// back end: block buffer, padding, 64-round compression and digest output
// depends on sha_pkg
module sha_back
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  item_t       q_item,
  input  logic        q_empty,
  output logic        pop,
  output logic        valid,
  input  logic        ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  back_state_t state, state_next;
  logic [31:0] hv [8];
  logic [31:0] wv [8];
  logic [31:0] win [16];
  logic [31:0] blk [16];
  logic [63:0] message_bits;
  logic [5:0]  rnd;
  logic        final_blk, two_blk, padded;
  logic [2:0]  widx;

  logic [5:0]  fill;
  logic [31:0] w, t1, t2, s0, s1;
  logic [31:0] pad_blk [16];
  logic [5:0]  pidx;
  logic [7:0]  pbyte;

  assign fill = message_bits[8:3];

  always_comb begin
    s0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
    s1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
    w = (rnd < 6'd16) ? blk[rnd[3:0]] : (s1 + win[9] + s0 + win[0]);
    t1 = wv[7] + (rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25))
       + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + round_k(rnd) + w;
    t2 = (rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22))
       + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  // padded block: mark, zeros and big-endian bit length
  always_comb begin
    pidx = '0;
    pbyte = '0;
    for (int j = 0; j < 16; j++) begin
      for (int b = 0; b < 4; b++) begin
        pidx = 6'(4*j + b);
        pbyte = blk[j][31-8*b -: 8];
        if (two_blk) pbyte = 8'h00;
        else if (pidx == fill) pbyte = PadMark;
        else if (pidx > fill) pbyte = 8'h00;
        if ((two_blk || fill < LenPos) && pidx >= LenPos)
          pbyte = message_bits[{~pidx[2:0], 3'b000} +: 8];
        pad_blk[j][31-8*b -: 8] = pbyte;
      end
    end
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    unique case (state)
      ST_IDLE: if (!q_empty) begin
        pop = 1'b1;
        if (q_item.has_byte && fill == 6'd63) state_next = ST_ROUND;
        else if (q_item.last) state_next = ST_PAD;
      end
      ST_PAD:   state_next = ST_ROUND;
      ST_ROUND: if (rnd == 6'd63) state_next = ST_FOLD;
      ST_FOLD:  state_next = !final_blk ? ST_IDLE :
                             ((!padded || two_blk) ? ST_PAD : ST_EMIT);
      ST_EMIT:  if (ready && widx == 3'd7) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign valid = (state == ST_EMIT);
  assign digest_word = hv[widx];
  assign word_index = widx;
  assign last_word = (widx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      message_bits <= '0;
      rnd <= '0;
      widx <= '0;
      final_blk <= 1'b0;
      two_blk <= 1'b0;
      padded <= 1'b0;
      for (int j = 0; j < 8; j++) hv[j] <= InitHash[255-32*j -: 32];
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: if (!q_empty) begin
          if (q_item.has_byte) begin
            blk[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= q_item.data_byte;
            message_bits <= message_bits + 64'd8;
          end
          final_blk <= q_item.last;
          two_blk <= 1'b0;
          padded <= 1'b0;
          rnd <= '0;
          for (int j = 0; j < 8; j++) wv[j] <= hv[j];
        end
        ST_PAD: begin
          rnd <= '0;
          padded <= 1'b1;
          for (int j = 0; j < 8; j++) wv[j] <= hv[j];
          for (int j = 0; j < 16; j++) blk[j] <= pad_blk[j];
          two_blk <= !two_blk && (fill >= LenPos);
        end
        ST_ROUND: begin
          for (int j = 0; j < 15; j++) win[j] <= win[j+1];
          win[15] <= w;
          wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4]; wv[4] <= wv[3] + t1;
          wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0]; wv[0] <= t1 + t2;
          rnd <= rnd + 6'd1;
        end
        ST_FOLD: begin
          for (int j = 0; j < 8; j++) hv[j] <= hv[j] + wv[j];
          widx <= '0;
        end
        ST_EMIT: if (ready) begin
          widx <= widx + 3'd1;
          if (widx == 3'd7) begin
            for (int j = 0; j < 8; j++) hv[j] <= InitHash[255-32*j -: 32];
            message_bits <= '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/core/sha256_byte_stream_hasher_unit.sv
// top level of the sha-256 byte stream hasher
// depends on sha_pkg, sha_front, sha_back, assert_macros.svh
//
// in channel: valid/ready with data_byte, has_byte, last, one byte per item.
// an item with neither byte nor last is taken and does nothing.
// a four-entry queue sits in front of the compression engine, so the sender
// is stalled only when it fills.
// bytes are taken from the queue while the engine is idle; the 64th byte of a
// block starts the rounds and a fold, during which no bytes are taken, so the
// sustained rate is set by the single shared round unit.
// on last, each final block takes a pad step, the rounds and a fold; one
// block, or two when the length no longer fits, and a byte with last that
// completes a block first goes through the rounds and fold on that block.
// then eight digest items go out on the out channel (valid/ready) with
// word_index 0..7 and last_word on word 7.
// a stalled receiver holds the current digest word; the queue keeps taking
// items until full.
// reset restores the initial hash and zero length; no clearing pass.
`include "assert_macros.svh"
module sha256_byte_stream_hasher_unit
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  logic pop, empty;
  item_t q_item;

  sha_front u_front (
    .clk, .rst, .valid_in(in_valid), .ready_in(in_ready), .data_byte, .has_byte,
    .last, .pop, .pop_item(q_item), .empty
  );

  sha_back u_back (
    .clk, .rst, .q_item, .q_empty(empty), .pop, .valid(out_valid), .ready(out_ready),
    .digest_word, .word_index, .last_word
  );

  `CHK_IMPL(a_last_idx, clk, rst, out_valid && last_word, word_index == 3'd7)
  `CHK_NEXT(a_idx_step, clk, rst, out_valid && out_ready && !last_word,
    out_valid && word_index == $past(word_index) + 3'd1)
  `CHK_IMPL(a_pop_nonempty, clk, rst, pop, !empty)
endmodule

>>> tb/tb_top.sv
// self-checking testbench for sha256_byte_stream_hasher_unit
// byte items are hashed by a sha-256 predictor and digest words are compared in order
// depends on sha_pkg and the rtl of the hasher
`timescale 1ns / 100ps
module tb_top;
  import sha_pkg::*;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  localparam logic [255:0] IvConst = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [31:0] KTab [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam int CycleLimit = 400000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha256_byte_stream_hasher_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .has_byte(has_byte), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .digest_word(digest_word),
    .word_index(word_index), .last_word(last_word)
  );

  logic [31:0]  hash_state [8];
  logic [7:0]   msg_block [64];
  logic [63:0]  bit_count;
  digest_item_t digest_queue [$];
  int           mismatch_count;
  int           cycle_count;
  int           send_idle_pct;
  int           recv_idle_pct;

  function automatic logic [31:0] ror32(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, t1, t2;
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        wt = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      end else begin
        wt = (ror32(w[(i-2)&15], 17) ^ ror32(w[(i-2)&15], 19) ^ (w[(i-2)&15] >> 10))
           + w[(i-7)&15]
           + (ror32(w[(i-15)&15], 7) ^ ror32(w[(i-15)&15], 18) ^ (w[(i-15)&15] >> 3))
           + w[i&15];
      end
      w[i&15] = wt;
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[i] + wt;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic hash_reset();
    for (int i = 0; i < 8; i++) hash_state[i] = IvConst[255 - 32*i -: 32];
    bit_count = '0;
  endtask

  task automatic predict_digest(byte_item_t it);
    int fill;
    logic [63:0] len;
    digest_item_t d;
    if (it.has_byte) begin
      fill = int'(bit_count[8:3]);
      msg_block[fill] = it.data_byte;
      bit_count += 64'd8;
      if (fill == 63) compress_block();
    end
    if (!it.last) return;
    len = bit_count;
    fill = int'(bit_count[8:3]);
    msg_block[fill++] = 8'h80;
    if (fill > 56) begin
      while (fill < 64) msg_block[fill++] = 8'h00;
      compress_block();
      fill = 0;
    end
    while (fill < 56) msg_block[fill++] = 8'h00;
    for (int i = 0; i < 8; i++) msg_block[56 + i] = len[63 - 8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      d.digest_word = hash_state[i];
      d.word_index = 3'(i);
      d.last_word = (i == 7);
      digest_queue.insert(digest_queue.size(), d);
    end
    hash_reset();
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // receiver: random stall, compare on accept
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (digest_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected digest item %h idx %0d", digest_word, word_index);
        end else begin
          digest_item_t e;
          e = digest_queue.pop_front();
          if (e.digest_word !== digest_word || e.word_index !== word_index ||
              e.last_word !== last_word) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                e.digest_word, e.word_index, e.last_word,
                digest_word, word_index, last_word);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // drive one item and wait for its accept
  task automatic send_item(byte_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= it.data_byte;
    has_byte  <= it.has_byte;
    last      <= it.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_digest(it);
  endtask

  task automatic send_message(int len, bit last_empty);
    byte_item_t it;
    for (int i = 0; i < len; i++) begin
      it.data_byte = 8'($urandom);
      it.has_byte = 1'b1;
      it.last = (!last_empty && i == len - 1);
      if ($urandom_range(9) == 0) begin
        byte_item_t n;
        n.data_byte = 8'($urandom);
        n.has_byte = 1'b0;
        n.last = 1'b0;
        send_item(n);
      end
      send_item(it);
    end
    if (last_empty || len == 0) begin
      it.data_byte = 8'($urandom);
      it.has_byte = 1'b0;
      it.last = 1'b1;
      send_item(it);
    end
  endtask

  byte_item_t directed_rows [] = '{
    '{8'h00, 1'b0, 1'b1},
    '{8'hff, 1'b1, 1'b1},
    '{8'h00, 1'b1, 1'b1},
    '{8'h61, 1'b1, 1'b0}, '{8'h62, 1'b1, 1'b0}, '{8'h63, 1'b1, 1'b1},
    '{8'h5a, 1'b0, 1'b0},
    '{8'ha5, 1'b1, 1'b0}, '{8'h3c, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b1}
  };

  initial begin
    int total;
    int lens [] = '{55, 56, 64, 63};
    mismatch_count = 0;
    send_idle_pct = 21;
    recv_idle_pct = 49;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    has_byte = 1'b0;
    last = 1'b0;
    hash_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed items: the empty message (digest read off the standard), single bytes, abc and items without a byte
    foreach (directed_rows[i]) send_item(directed_rows[i]);
    // padding boundaries: 55, 56, 64 and 63 byte messages
    foreach (lens[i]) send_message(lens[i], 1'(i % 2));
    total = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 49 : 0;
      recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 21 : 0;
      while (total < 35 * (ph + 1)) begin
        int n;
        n = ($urandom_range(7) == 0) ? $urandom_range(56, 72) : $urandom_range(0, 20);
        send_message(n, $urandom_range(3) == 0);
        total += n + 1;
      end
    end
    in_valid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && digest_queue.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // first digest word after reset must be word 0 of the empty-message hash
  initial begin
    wait (!rst);
    @(posedge clk iff (out_valid && out_ready));
    if (digest_word !== 32'he3b0c442 || word_index !== 3'd0) begin
      mismatch_count++;
      $display("empty digest word 0: exp e3b0c442 got %h", digest_word);
    end
  end
endmodule
